FILE: hw/rtl/sphk_pkg.sv
// shared types and constants of the sph kernel evaluator
package sphk_pkg;

	typedef enum logic [2:0] {
		KIND_POLY6      = 3'd0,
		KIND_POLY6_GRAD = 3'd1,
		KIND_POLY6_LAP  = 3'd2,
		KIND_SPIKY_GRAD = 3'd3,
		KIND_VISC_LAP   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		REG_SUPPORT_RADIUS = 2'd0,
		REG_NORM_EIGHTH    = 2'd1,
		REG_NORM_FOURTH    = 2'd2,
		REG_INV_RADIUS     = 2'd3
	} cfg_reg_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int RADIUS_W   = 15;
	localparam int NORM_W     = 32;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd4096;
	localparam logic [NORM_W-1:0]   NORM8_RESET  = 32'd5340507;
	localparam logic [NORM_W-1:0]   NORM4_RESET  = 32'd5340507;
	localparam logic [NORM_W-1:0]   INV_R_RESET  = 32'd16777216;

	localparam int SQRT_STEPS = 27;
	localparam int DIV_STEPS  = 25;

	localparam int K_POLY6_GRAD = 24;
	localparam int K_POLY6_LAP  = 48;
	localparam int K_SPIKY      = 30;
	localparam int K_VISC       = 40;

	// per-item working set, fixed widths once the radius test has passed
	typedef struct packed {
		logic [2:0]             kind;
		logic                   in_range;
		logic                   zero_d;
		logic [2:0]             neg;
		logic [2:0][14:0]       mag;
		logic [29:0]            d;
		logic                   e_pos;
		logic [31:0]            ue;
		logic [53:0]            rad;
		logic [26:0]            root;
		logic [58:0]            qprod;
		logic [35:0]            d2;
		logic [24:0]            w;
		logic [41:0]            d3;
		logic [43:0]            g1;
		logic [37:0]            ep;
		logic [24:0]            ww;
		logic [56:0]            vw;
		logic [41:0]            v0;
		logic [48:0]            c1;
		logic [43:0]            p2;
		logic [32:0]            x;
		logic [29:0]            visc;
		logic [43:0]            lap;
		logic [2:0][43:0]       pg;
		logic [52:0]            m;
		logic [2:0][50:0]       rem;
		logic [2:0][24:0]       u;
		logic [2:0][33:0]       sg;
	} work_t;

endpackage

FILE: hw/rtl/sphk_pair_if.sv
// request channel: kernel selector and pair displacement
interface sphk_pair_if #(parameter int COMP_BITS = 16);
	logic                        valid;
	logic                        ready;
	logic [2:0]                  kind;
	logic signed [COMP_BITS-1:0] disp_x;
	logic signed [COMP_BITS-1:0] disp_y;
	logic signed [COMP_BITS-1:0] disp_z;

	modport source(output valid, kind, disp_x, disp_y, disp_z, input ready);
	modport sink(input valid, kind, disp_x, disp_y, disp_z, output ready);
endinterface

FILE: hw/rtl/sphk_result_if.sv
// result channel: kernel value, gradient and flags
interface sphk_result_if #(parameter int OUT_BITS = 32);
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] scalar_value;
	logic signed [OUT_BITS-1:0] grad_x;
	logic signed [OUT_BITS-1:0] grad_y;
	logic signed [OUT_BITS-1:0] grad_z;
	logic                       in_range;
	logic                       zero_distance;
	logic                       saturated;

	modport source(output valid, scalar_value, grad_x, grad_y, grad_z, in_range,
		zero_distance, saturated, input ready);
	modport sink(input valid, scalar_value, grad_x, grad_y, grad_z, in_range,
		zero_distance, saturated, output ready);
endinterface

FILE: hw/rtl/sph_kernel_evaluator.sv
// sph smoothing kernel evaluator: pipelined poly6, spiky and viscosity kernels
//
// One pair request enters per clock while results are taken; every result passes
// through the 27-stage square root of |r|^2 followed by the 25-stage
// divider that forms the unit vector for the spiky gradient, with every kernel
// kind taking the same path. A stall on the result side freezes the whole pipe,
// so the sustained rate stays one pair per cycle while results are taken.
// Registers must be written through cfg_we/cfg_index/cfg_data only while no request
// is in flight, which the block does not enforce: 0 support radius, 1 norm_eighth, 2 norm_fourth, 3 inv_radius.
module sph_kernel_evaluator #(
	parameter int COMP_BITS = 16,
	parameter int OUT_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sphk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sphk_pkg::CFG_DATA_W-1:0]     cfg_data,
	sphk_pair_if.sink                           pair,
	sphk_result_if.source                       result
);

	localparam int SQ_W  = 2 * COMP_BITS;
	localparam int MAG_W = (OUT_BITS > 44) ? OUT_BITS + 1 : 45;
	localparam logic [MAG_W-1:0] OUT_HALF = {{(MAG_W-1){1'b0}}, 1'b1} << (OUT_BITS - 1);

	// configuration
	logic [sphk_pkg::RADIUS_W-1:0] radius_q;
	logic [sphk_pkg::NORM_W-1:0]   norm8_q;
	logic [sphk_pkg::NORM_W-1:0]   norm4_q;
	logic [sphk_pkg::NORM_W-1:0]   inv_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= sphk_pkg::RADIUS_RESET;
			norm8_q  <= sphk_pkg::NORM8_RESET;
			norm4_q  <= sphk_pkg::NORM4_RESET;
			inv_r_q  <= sphk_pkg::INV_R_RESET;
		end else if (cfg_we) begin
			unique case (sphk_pkg::cfg_reg_t'(cfg_index))
				sphk_pkg::REG_SUPPORT_RADIUS: radius_q <= cfg_data[sphk_pkg::RADIUS_W-1:0];
				sphk_pkg::REG_NORM_EIGHTH:    norm8_q  <= cfg_data;
				sphk_pkg::REG_NORM_FOURTH:    norm4_q  <= cfg_data;
				sphk_pkg::REG_INV_RADIUS:     inv_r_q  <= cfg_data;
			endcase
		end
	end

	logic [29:0] hsq;
	logic [19:0] h30;
	assign hsq = 30'(radius_q) * 30'(radius_q);
	assign h30 = 20'(radius_q) * 20'(sphk_pkg::K_SPIKY);

	// pipeline enable: everything moves unless a finished result is held
	logic out_vld_q;
	logic en;
	assign en         = !out_vld_q || result.ready;
	assign pair.ready = en;

	// stage 1: magnitudes and signs
	logic                        vld_s1;
	logic [2:0]                  kind_s1;
	logic [2:0]                  neg_s1;
	logic [2:0][COMP_BITS-1:0]   mag_s1;
	logic [2:0][COMP_BITS-1:0]   raw;

	assign raw[0] = pair.disp_x;
	assign raw[1] = pair.disp_y;
	assign raw[2] = pair.disp_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= pair.kind;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw[i][COMP_BITS-1];
				mag_s1[i] <= raw[i][COMP_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
			end
		end
	end

	// stage 2: squared distance
	logic                      vld_s2;
	logic [2:0]                kind_s2;
	logic [2:0]                neg_s2;
	logic [2:0][COMP_BITS-1:0] mag_s2;
	logic [SQ_W-1:0]           sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			sq_s2   <= SQ_W'(mag_s1[0]) * SQ_W'(mag_s1[0])
				+ SQ_W'(mag_s1[1]) * SQ_W'(mag_s1[1])
				+ SQ_W'(mag_s1[2]) * SQ_W'(mag_s1[2]);
		end
	end

	// stage 3: radius test, d = h^2 - |r|^2, e = h^2 - 3|r|^2
	logic             vld_s3;
	sphk_pkg::work_t  wk_s3;
	sphk_pkg::work_t  nx_s3;

	always_comb begin
		logic [29:0] sq30;
		logic [31:0] sq3;
		nx_s3          = '0;
		sq30           = 30'(sq_s2);
		sq3            = 32'(sq30) * 32'd3;
		nx_s3.kind     = kind_s2;
		nx_s3.in_range = 64'(sq_s2) <= 64'(hsq);
		nx_s3.zero_d   = (sq_s2 == '0);
		nx_s3.neg      = neg_s2;
		for (int i = 0; i < 3; i++) begin
			nx_s3.mag[i] = 15'(mag_s2[i]);
		end
		nx_s3.d        = hsq - sq30;
		nx_s3.e_pos    = 32'(hsq) > sq3;
		nx_s3.ue       = nx_s3.e_pos ? (32'(hsq) - sq3) : (sq3 - 32'(hsq));
		nx_s3.rad      = {sq30, 24'd0};
		nx_s3.root     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wk_s3 <= nx_s3;
		end
	end

	// square root, one result bit per stage
	sphk_pkg::work_t wk_sqrt_s [sphk_pkg::SQRT_STEPS];
	logic            vld_sqrt_s [sphk_pkg::SQRT_STEPS];

	for (genvar k = 0; k < sphk_pkg::SQRT_STEPS; k++) begin : g_sqrt
		localparam int B = sphk_pkg::SQRT_STEPS - 1 - k;
		sphk_pkg::work_t wi;
		logic            vi;
		sphk_pkg::work_t wo;

		if (k == 0) begin : g_first
			assign wi = wk_s3;
			assign vi = vld_s3;
		end else begin : g_next
			assign wi = wk_sqrt_s[k-1];
			assign vi = vld_sqrt_s[k-1];
		end

		always_comb begin
			logic [55:0] t;
			wo = wi;
			t  = (56'(wi.root) << (B + 1)) + (56'd1 << (2 * B));
			if (56'(wi.rad) >= t) begin
				wo.rad  = 54'(56'(wi.rad) - t);
				wo.root = wi.root | (27'd1 << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sqrt_s[k] <= 1'b0;
			end else if (en) begin
				vld_sqrt_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				wk_sqrt_s[k] <= wo;
			end
		end
	end

	// product stages p1..p5
	sphk_pkg::work_t wk_p1, wk_p2, wk_p3, wk_p4, wk_p5;
	sphk_pkg::work_t nx_p1, nx_p2, nx_p3, nx_p4, nx_p5;
	logic            vld_p1, vld_p2, vld_p3, vld_p4, vld_p5;

	always_comb begin
		nx_p1       = wk_sqrt_s[sphk_pkg::SQRT_STEPS-1];
		nx_p1.qprod = 59'(nx_p1.root) * 59'(inv_r_q);
		nx_p1.d2    = 36'((60'(nx_p1.d) * 60'(nx_p1.d)) >> 24);
	end

	always_comb begin
		logic [34:0] q;
		nx_p2    = wk_p1;
		q        = wk_p1.qprod[58:24];
		// q above one clamps 1 - q to zero
		nx_p2.w  = (q >= (35'd1 << 24)) ? 25'd0 : 25'((35'd1 << 24) - q);
		nx_p2.d3 = 42'((66'(wk_p1.d2) * 66'(wk_p1.d)) >> 24);
		nx_p2.g1 = 44'((68'(wk_p1.d2) * 68'(norm8_q)) >> 24);
		nx_p2.ep = 38'((62'(wk_p1.d) * 62'(wk_p1.ue)) >> 24);
	end

	always_comb begin
		nx_p3    = wk_p2;
		nx_p3.ww = 25'((50'(wk_p2.w) * 50'(wk_p2.w)) >> 24);
		nx_p3.vw = 57'(wk_p2.w) * 57'(norm4_q);
		nx_p3.v0 = 42'((74'(wk_p2.d3) * 74'(norm8_q)) >> 32);
		nx_p3.c1 = 49'(wk_p2.g1) * 49'(sphk_pkg::K_POLY6_GRAD);
		nx_p3.p2 = 44'(wk_p2.ep) * 44'(sphk_pkg::K_POLY6_LAP);
	end

	always_comb begin
		nx_p4      = wk_p3;
		nx_p4.x    = 33'((57'(wk_p3.ww) * 57'(norm4_q)) >> 24);
		nx_p4.visc = 30'((63'(wk_p3.vw) * 63'(sphk_pkg::K_VISC)) >> 32);
		nx_p4.lap  = 44'((76'(wk_p3.p2) * 76'(norm8_q)) >> 32);
		for (int i = 0; i < 3; i++) begin
			nx_p4.pg[i] = 44'((64'(wk_p3.c1) * 64'(wk_p3.mag[i])) >> 20);
		end
	end

	always_comb begin
		nx_p5   = wk_p4;
		nx_p5.m = 53'(wk_p4.x) * 53'(h30);
		for (int i = 0; i < 3; i++) begin
			nx_p5.rem[i] = {wk_p4.mag[i], 36'd0};
			nx_p5.u[i]   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
			vld_p5 <= 1'b0;
		end else if (en) begin
			vld_p1 <= vld_sqrt_s[sphk_pkg::SQRT_STEPS-1];
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			vld_p4 <= vld_p3;
			vld_p5 <= vld_p4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wk_p1 <= nx_p1;
			wk_p2 <= nx_p2;
			wk_p3 <= nx_p3;
			wk_p4 <= nx_p4;
			wk_p5 <= nx_p5;
		end
	end

	// unit vector divider, one quotient bit per stage on all three lanes
	sphk_pkg::work_t wk_div_s [sphk_pkg::DIV_STEPS];
	logic            vld_div_s [sphk_pkg::DIV_STEPS];

	for (genvar k = 0; k < sphk_pkg::DIV_STEPS; k++) begin : g_div
		localparam int B = sphk_pkg::DIV_STEPS - 1 - k;
		sphk_pkg::work_t wi;
		logic            vi;
		sphk_pkg::work_t wo;

		if (k == 0) begin : g_first
			assign wi = wk_p5;
			assign vi = vld_p5;
		end else begin : g_next
			assign wi = wk_div_s[k-1];
			assign vi = vld_div_s[k-1];
		end

		always_comb begin
			logic [51:0] t;
			wo = wi;
			t  = 52'(wi.root) << B;
			for (int i = 0; i < 3; i++) begin
				if (52'(wi.rem[i]) >= t) begin
					wo.rem[i] = 51'(52'(wi.rem[i]) - t);
					wo.u[i]   = wi.u[i] | (25'd1 << B);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_div_s[k] <= 1'b0;
			end else if (en) begin
				vld_div_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				wk_div_s[k] <= wo;
			end
		end
	end

	// spiky gradient components
	sphk_pkg::work_t wk_f1;
	sphk_pkg::work_t nx_f1;
	logic            vld_f1;

	always_comb begin
		nx_f1 = wk_div_s[sphk_pkg::DIV_STEPS-1];
		for (int i = 0; i < 3; i++) begin
			nx_f1.sg[i] = 34'((78'(nx_f1.m) * 78'(nx_f1.u[i])) >> 44);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
		end else if (en) begin
			vld_f1 <= vld_div_s[sphk_pkg::DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wk_f1 <= nx_f1;
		end
	end

	// sign, clip and select
	function automatic logic [OUT_BITS:0] sat_out(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] lim;
		logic [MAG_W-1:0] mv;
		logic [MAG_W-1:0] nv;
		logic             clip;
		lim  = neg ? OUT_HALF : OUT_HALF - 1'b1;
		clip = mag > lim;
		mv   = clip ? lim : mag;
		nv   = ~mv + 1'b1;
		return {clip, neg ? nv[OUT_BITS-1:0] : mv[OUT_BITS-1:0]};
	endfunction

	logic [OUT_BITS-1:0] scalar_d;
	logic [2:0][OUT_BITS-1:0] grad_d;
	logic                in_range_d;
	logic                zero_d;
	logic                sat_d;

	always_comb begin
		logic [OUT_BITS:0] r;
		scalar_d   = '0;
		grad_d     = '0;
		in_range_d = wk_f1.in_range;
		zero_d     = 1'b0;
		sat_d      = 1'b0;
		r          = '0;
		if (wk_f1.in_range) begin
			case (sphk_pkg::kind_t'(wk_f1.kind))
				sphk_pkg::KIND_POLY6: begin
					r        = sat_out(1'b0, MAG_W'(wk_f1.v0));
					scalar_d = r[OUT_BITS-1:0];
					sat_d    = r[OUT_BITS];
				end
				sphk_pkg::KIND_POLY6_GRAD: begin
					for (int i = 0; i < 3; i++) begin
						r         = sat_out(!wk_f1.neg[i], MAG_W'(wk_f1.pg[i]));
						grad_d[i] = r[OUT_BITS-1:0];
						sat_d     = sat_d | r[OUT_BITS];
					end
				end
				sphk_pkg::KIND_POLY6_LAP: begin
					// negative where h^2 > 3|r|^2
					r        = sat_out(wk_f1.e_pos, MAG_W'(wk_f1.lap));
					scalar_d = r[OUT_BITS-1:0];
					sat_d    = r[OUT_BITS];
				end
				sphk_pkg::KIND_SPIKY_GRAD: begin
					if (wk_f1.zero_d) begin
						zero_d = 1'b1;
					end else begin
						for (int i = 0; i < 3; i++) begin
							r         = sat_out(!wk_f1.neg[i], MAG_W'(wk_f1.sg[i]));
							grad_d[i] = r[OUT_BITS-1:0];
							sat_d     = sat_d | r[OUT_BITS];
						end
					end
				end
				sphk_pkg::KIND_VISC_LAP: begin
					r        = sat_out(1'b0, MAG_W'(wk_f1.visc));
					scalar_d = r[OUT_BITS-1:0];
					sat_d    = r[OUT_BITS];
				end
				default: begin
					scalar_d = '0;
				end
			endcase
		end
	end

	logic [OUT_BITS-1:0] scalar_q;
	logic [2:0][OUT_BITS-1:0] grad_q;
	logic                in_range_q;
	logic                zero_q;
	logic                sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scalar_q   <= scalar_d;
			grad_q     <= grad_d;
			in_range_q <= in_range_d;
			zero_q     <= zero_d;
			sat_q      <= sat_d;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.scalar_value  = scalar_q;
	assign result.grad_x        = grad_q[0];
	assign result.grad_y        = grad_q[1];
	assign result.grad_z        = grad_q[2];
	assign result.in_range      = in_range_q;
	assign result.zero_distance = zero_q;
	assign result.saturated     = sat_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pair.valid && pair.ready) |=> vld_s1)
		else $error("accepted request did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_f1) && $stable(vld_p5) && $stable(vld_s3)))
		else $error("pipeline moved during a stall");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.in_range) |-> (result.scalar_value == '0
		&& result.grad_x == '0 && result.grad_y == '0 && result.grad_z == '0
		&& !result.zero_distance && !result.saturated))
		else $error("out of range result carries data");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.zero_distance) |-> (result.in_range
		&& result.grad_x == '0 && result.grad_y == '0 && result.grad_z == '0))
		else $error("zero distance result is not a zero vector");

endmodule

FILE: test/testbench.sv
// self-checking testbench for the sph kernel evaluator: random pair streams against a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 62;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
	localparam logic [63:0] PRODUCT_CAP = 64'd1 << 62;
	localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
	// long receiver hold-offs start early in a phase so the sender still has plenty to offer
	localparam int HOLD_AT_FIRST  = 430;
	localparam int HOLD_AT_SECOND = 1230;

	typedef struct {
		logic [2:0]         kind;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
	} pair_req_t;

	typedef struct {
		logic [31:0] scalar_value;
		logic [31:0] grad[3];
		logic        in_range;
		logic        zero_distance;
		logic        saturated;
	} kernel_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sphk_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sphk_pkg::CFG_DATA_W-1:0] cfg_data;

	sphk_pair_if #(.COMP_BITS(16)) pair_ch();
	sphk_result_if #(.OUT_BITS(32)) res_ch();

	sph_kernel_evaluator #(.COMP_BITS(16), .OUT_BITS(32)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pair(pair_ch),
		.result(res_ch)
	);

	// register copies used by the predictor
	logic [14:0] radius_q12;
	logic [31:0] norm8_q24;
	logic [31:0] norm4_q24;
	logic [31:0] inv_radius_q24;

	pair_req_t pending_pairs[$];
	kernel_result_t expected_results[$];
	int error_count = 0;
	int cycle_count = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> sh;
		if (prod > {64'd0, PRODUCT_CAP})
			return PRODUCT_CAP;
		return prod[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] clip_signed(logic neg, logic [63:0] mag, ref logic sat);
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (mag > lim) begin
			mag = lim;
			sat = 1'b1;
		end
		return neg ? 32'(64'd0 - mag) : mag[31:0];
	endfunction

	// 1 - |r|/h in Q.24, zero once q passes one
	function automatic logic [63:0] one_minus_q(logic [63:0] sq, output logic [63:0] root_len);
		logic [63:0] q;
		root_len = int_sqrt(sq << 24);
		q = (root_len * {32'd0, inv_radius_q24}) >> 24;
		return (q >= ONE_Q24) ? 64'd0 : ONE_Q24 - q;
	endfunction

	function automatic kernel_result_t eval_kernel(pair_req_t p);
		kernel_result_t res;
		logic [15:0] raw[3];
		logic [63:0] mag[3];
		logic neg[3];
		logic [63:0] sq, hsq, d, root_len, w, m, v, u;
		logic signed [63:0] e;
		logic sat;
		raw[0] = p.dx;
		raw[1] = p.dy;
		raw[2] = p.dz;
		sq = 0;
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = raw[i][15];
			mag[i] = neg[i] ? {48'd0, 16'(-raw[i])} : {48'd0, raw[i]};
			sq = sq + mag[i] * mag[i];
		end
		hsq = {49'd0, radius_q12} * {49'd0, radius_q12};
		res.scalar_value = 0;
		for (int i = 0; i < 3; i++)
			res.grad[i] = 0;
		res.in_range = 1'b0;
		res.zero_distance = 1'b0;
		res.saturated = 1'b0;
		if (sq > hsq)
			return res;
		res.in_range = 1'b1;
		if (p.kind > sphk_pkg::KIND_VISC_LAP)
			return res;
		d = hsq - sq;
		case (sphk_pkg::kind_t'(p.kind))
			sphk_pkg::KIND_POLY6: begin
				v = mul_shift(mul_shift(mul_shift(d, d, 24), d, 24), {32'd0, norm8_q24}, 32);
				res.scalar_value = clip_signed(1'b0, v, sat);
			end
			sphk_pkg::KIND_POLY6_GRAD: begin
				m = mul_shift(mul_shift(d, d, 24), {32'd0, norm8_q24}, 24)
					* sphk_pkg::K_POLY6_GRAD;
				for (int i = 0; i < 3; i++)
					res.grad[i] = clip_signed(!neg[i], mul_shift(m, mag[i], 20), sat);
			end
			sphk_pkg::KIND_POLY6_LAP: begin
				e = $signed(hsq) - 3 * $signed(sq);
				m = mul_shift(d, (e < 0) ? 64'(-e) : 64'(e), 24) * sphk_pkg::K_POLY6_LAP;
				v = mul_shift(m, {32'd0, norm8_q24}, 32);
				res.scalar_value = clip_signed(e > 0, v, sat);
			end
			sphk_pkg::KIND_SPIKY_GRAD: begin
				if (sq == 0) begin
					res.zero_distance = 1'b1;
				end else begin
					w = one_minus_q(sq, root_len);
					m = ((((w * w) >> 24) * {32'd0, norm4_q24}) >> 24) * sphk_pkg::K_SPIKY
						* {49'd0, radius_q12};
					for (int i = 0; i < 3; i++) begin
						u = (mag[i] << 36) / root_len;
						res.grad[i] = clip_signed(!neg[i], mul_shift(m, u, 44), sat);
					end
				end
			end
			default: begin
				w = one_minus_q(sq, root_len);
				v = (w * {32'd0, norm4_q24} * sphk_pkg::K_VISC) >> 32;
				res.scalar_value = clip_signed(1'b0, v, sat);
			end
		endcase
		res.saturated = sat;
		return res;
	endfunction

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin : pair_driver
		pair_req_t nxt;
		pair_req_t took;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			pair_ch.valid <= 1'b0;
			pair_ch.kind <= '0;
			pair_ch.disp_x <= '0;
			pair_ch.disp_y <= '0;
			pair_ch.disp_z <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (pair_ch.valid && pair_ch.ready) begin
				took.kind = pair_ch.kind;
				took.dx = pair_ch.disp_x;
				took.dy = pair_ch.disp_y;
				took.dz = pair_ch.disp_z;
				expected_results.push_back(eval_kernel(took));
			end
			if (!(pair_ch.valid && !pair_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					pair_ch.valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					nxt = pending_pairs.pop_front();
					pair_ch.kind <= nxt.kind;
					pair_ch.disp_x <= nxt.dx;
					pair_ch.disp_y <= nxt.dy;
					pair_ch.disp_z <= nxt.dz;
					pair_ch.valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					pair_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern plus two long hold-offs that back up the pipe
	always @(posedge clk or negedge arst_n) begin : result_sink
		int taken;
		int long_left;
		int mode;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			taken = 0;
			long_left = 0;
			mode = 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				taken++;
			if (cycle_count % 64 == 0)
				mode = $urandom_range(0, 2);
			if (long_left > 0) begin
				long_left--;
				res_ch.ready <= 1'b0;
			end else if (res_ch.valid && res_ch.ready
				&& (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND)) begin
				long_left = 300;
				res_ch.ready <= 1'b0;
			end else if (mode == 0) begin
				res_ch.ready <= 1'b1;
			end else if (mode == 1) begin
				res_ch.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				res_ch.ready <= ($urandom_range(0, 9) < 3);
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)", name,
				$signed(exp_v), exp_v, $signed(act_v), act_v);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		kernel_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("scalar_value", want.scalar_value, res_ch.scalar_value);
				check_field("grad_x", want.grad[0], res_ch.grad_x);
				check_field("grad_y", want.grad[1], res_ch.grad_y);
				check_field("grad_z", want.grad[2], res_ch.grad_z);
				check_field("in_range", 32'(want.in_range), 32'(res_ch.in_range));
				check_field("zero_distance", 32'(want.zero_distance), 32'(res_ch.zero_distance));
				check_field("saturated", 32'(want.saturated), 32'(res_ch.saturated));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(sphk_pkg::cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sphk_pkg::REG_SUPPORT_RADIUS: radius_q12 = val[14:0];
			sphk_pkg::REG_NORM_EIGHTH: norm8_q24 = val;
			sphk_pkg::REG_NORM_FOURTH: norm4_q24 = val;
			default: inv_radius_q24 = val;
		endcase
	endtask

	task automatic set_kernel_regs(logic [14:0] h, logic [31:0] n8, logic [31:0] n4,
		logic [31:0] inv_h);
		write_reg(sphk_pkg::REG_SUPPORT_RADIUS, {17'd0, h});
		write_reg(sphk_pkg::REG_NORM_EIGHTH, n8);
		write_reg(sphk_pkg::REG_NORM_FOURTH, n4);
		write_reg(sphk_pkg::REG_INV_RADIUS, inv_h);
	endtask

	// waits until every request is sent and every result is back, then gives the pipe time to empty
	task automatic drain();
		while (pending_pairs.size() > 0 || expected_results.size() > 0 || pair_ch.valid)
			@(posedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);
	endtask

	task automatic add_pair(logic [2:0] kind, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		pair_req_t p;
		p.kind = kind;
		p.dx = x;
		p.dy = y;
		p.dz = z;
		pending_pairs.push_back(p);
	endtask

	function automatic logic [15:0] rand_comp(int span);
		if ($urandom_range(0, 9) < 3)
			return 16'($urandom);
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic add_random_pairs(int count);
		logic [2:0] kind;
		int span;
		// most components stay inside the sphere so the kernels get exercised
		span = (int'(radius_q12) * 3) / 5;
		for (int i = 0; i < count; i++) begin
			kind = ($urandom_range(0, 15) == 0) ?
				3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)) :
				3'($urandom_range(sphk_pkg::KIND_POLY6, sphk_pkg::KIND_VISC_LAP));
			add_pair(kind, rand_comp(span), rand_comp(span), rand_comp(span));
		end
	endtask

	function automatic logic [31:0] inv_of(logic [14:0] h);
		logic [63:0] full;
		full = (64'd1 << 36) / {49'd0, h};
		return (full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : full[31:0];
	endfunction

	initial begin
		logic [14:0] h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		radius_q12 = sphk_pkg::RADIUS_RESET;
		norm8_q24 = sphk_pkg::NORM8_RESET;
		norm4_q24 = sphk_pkg::NORM4_RESET;
		inv_radius_q24 = sphk_pkg::INV_R_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs on the reset settings
		for (int k = sphk_pkg::KIND_POLY6; k <= sphk_pkg::KIND_VISC_LAP; k++) begin
			add_pair(3'(k), 16'sd0, 16'sd0, 16'sd0);
			add_pair(3'(k), 16'sd1200, -16'sd800, 16'sd300);
		end
		add_pair(sphk_pkg::KIND_POLY6, 16'sd4096, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_SPIKY_GRAD, 16'sd0, -16'sd4096, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6, 16'sd4097, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6_LAP, 16'sd2364, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6_LAP, 16'sd2365, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6_GRAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		add_pair(sphk_pkg::KIND_VISC_LAP, 16'sh8000, 16'sh8000, 16'sh8000);
		add_pair(KIND_SPARE_FIRST, 16'sd100, 16'sd0, 16'sd0);
		add_pair(KIND_SPARE_LAST, 16'sd9000, 16'sd0, 16'sd0);
		drain();

		// zero radius: only the origin is inside
		set_kernel_regs(15'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_pair(sphk_pkg::KIND_POLY6, 16'sd0, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_SPIKY_GRAD, 16'sd0, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6, 16'sd1, 16'sd0, 16'sd0);
		drain();

		// largest radius with largest normalizers drives saturation
		set_kernel_regs(15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, inv_of(15'h7FFF));
		add_pair(sphk_pkg::KIND_POLY6, 16'sd0, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6_GRAD, 16'sd100, -16'sd100, 16'sd1);
		add_pair(sphk_pkg::KIND_SPIKY_GRAD, 16'sd1, 16'sd0, 16'sd0);
		add_pair(sphk_pkg::KIND_POLY6_LAP, 16'sd0, 16'sd0, 16'sd0);
		add_random_pairs(150);
		drain();

		// inverse radius far too big, so q passes one
		set_kernel_regs(15'd4096, 32'd0, sphk_pkg::NORM4_RESET, 32'hFFFF_FFFF);
		add_random_pairs(150);
		drain();

		set_kernel_regs(15'd1, sphk_pkg::NORM8_RESET, 32'd0, inv_of(15'd1));
		add_random_pairs(100);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			h = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(1, 64)) :
				15'($urandom_range(1, 32767));
			set_kernel_regs(h, $urandom, $urandom,
				($urandom_range(0, 4) == 0) ? 32'($urandom) : inv_of(h));
			add_random_pairs(200);
			drain();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
